### src/olpd_pkg.sv
// Package: sizes, status codes and cell control type for the ordered list block.
`default_nettype none
package olpd_pkg;
    localparam int DEPTH       = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int ITEM_W      = 32;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 6;

    typedef logic [ITEM_W-1:0] t_item;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [IDX_W-1:0]  t_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_IGNORED  = 3'd2,
        ST_FULL     = 3'd3,
        ST_DRAINED  = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;
endpackage
`default_nettype wire

### src/olpd_if.sv
// Interfaces: command channel and result channel with valid/ready handshake.
`default_nettype none
interface olpd_in_if;
    import olpd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic signed [ITEM_W-1:0] value;
    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface olpd_out_if;
    import olpd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [ITEM_W-1:0] item_value;
    logic [COUNT_OUT_W-1:0]   count_after;
    logic                     last;
    modport source (output valid, output status, output item_value, output count_after,
                    output last, input ready);
    modport sink   (input valid, input status, input item_value, input count_after,
                    input last, output ready);
endinterface
`default_nettype wire

### src/olpd_cell.sv
// One list cell: holds one item, loads a new one or takes its upper neighbor's.
`default_nettype none
module olpd_cell (
    input  logic               i_clk,
    input  olpd_pkg::t_cell_ctl i_ctl,
    input  olpd_pkg::t_item    i_load_item,
    input  olpd_pkg::t_item    i_next_item,
    output olpd_pkg::t_item    o_item
);
    import olpd_pkg::*;

    t_item r_item;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_item <= i_load_item;
        end else if (i_ctl.shift) begin
            r_item <= i_next_item;
        end
    end

    assign o_item = r_item;
endmodule
`default_nettype wire

### src/ordered_list_positional_delete_core.sv
// Top level: ordered list with tail append, delete by position and drain.
//
//  channel | dir | handshake         | payload
//  i_in    | in  | valid/ready       | mode, value
//  o_out   | out | valid/ready       | status, item_value, count_after, last
//
// A command is taken into an input register and executed once the result register is
// free; one result per command, but a drain gives one result per held item.
// A drain first enters the drain state, then sends the held items in order; each item
// leaves cell 0 while the row of cells shifts one place toward the head.
// Synchronous active-low reset empties the list; cell contents are not reset.
// A stalled result holds the row; one further command waits in the input register.
`default_nettype none
module ordered_list_positional_delete_core (
    input  logic i_clk,
    input  logic i_rst_n,
    olpd_in_if.sink    i_in,
    olpd_out_if.source o_out
);
    import olpd_pkg::*;

    typedef enum logic {S_IDLE, S_DRAIN} t_state;

    t_state    r_state, n_state;
    logic      r_cmd_valid, n_cmd_valid;
    logic      r_mode, n_mode;
    t_item     r_value, n_value;
    t_count    r_count, n_count;
    logic      r_out_valid, n_out_valid;
    t_status   r_out_status, n_out_status;
    t_item     r_out_item, n_out_item;
    t_count    r_out_count, n_out_count;
    logic      r_out_last, n_out_last;

    t_cell_ctl cell_ctl  [DEPTH];
    t_item     cell_item [DEPTH];

    logic  out_free;
    logic  in_xfer;
    t_item mag;
    logic  del_ok;
    t_idx  pos;
    logic  full;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : gen_cell
            olpd_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (cell_ctl[g]),
                .i_load_item (r_value),
                .i_next_item (cell_item[(g < DEPTH - 1) ? g + 1 : g]),
                .o_item      (cell_item[g])
            );
        end
    endgenerate

    assign out_free = !r_out_valid || o_out.ready;
    assign in_xfer  = i_in.valid && i_in.ready;
    assign mag      = ~r_value + ITEM_W'(1);
    assign del_ok   = r_value[ITEM_W-1] && (mag < ITEM_W'(r_count));
    assign pos      = mag[IDX_W-1:0];
    assign full     = (r_count == CNT_W'(DEPTH));

    always_comb begin
        n_state      = r_state;
        n_cmd_valid  = r_cmd_valid;
        n_mode       = r_mode;
        n_value      = r_value;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_item   = r_out_item;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;
        for (int j = 0; j < DEPTH; j++) begin
            cell_ctl[j] = '0;
        end

        if (in_xfer) begin
            n_cmd_valid = 1'b1;
            n_mode      = i_in.mode;
            n_value     = i_in.value;
        end
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (r_cmd_valid && out_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_item  = '0;
                    n_out_count = r_count;
                    n_cmd_valid = 1'b0;
                    if (r_mode) begin
                        if (r_count == '0) begin
                            n_out_status = ST_EMPTY;
                        end else begin
                            // results come out of the drain state
                            n_out_valid = 1'b0;
                            n_cmd_valid = 1'b1;
                            n_state     = S_DRAIN;
                        end
                    end else if (!r_value[ITEM_W-1]) begin
                        if (full) begin
                            n_out_status = ST_FULL;
                        end else begin
                            cell_ctl[r_count[IDX_W-1:0]].load = 1'b1;
                            n_count      = r_count + CNT_W'(1);
                            n_out_count  = r_count + CNT_W'(1);
                            n_out_status = ST_APPENDED;
                        end
                    end else if (del_ok) begin
                        // cells at and above the deleted slot take their neighbor
                        for (int j = 0; j < DEPTH - 1; j++) begin
                            cell_ctl[j].shift = (IDX_W'(j) >= pos);
                        end
                        n_out_item   = cell_item[pos];
                        n_count      = r_count - CNT_W'(1);
                        n_out_count  = r_count - CNT_W'(1);
                        n_out_status = ST_REMOVED;
                    end else begin
                        n_out_status = ST_IGNORED;
                    end
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    for (int j = 0; j < DEPTH - 1; j++) begin
                        cell_ctl[j].shift = 1'b1;
                    end
                    n_out_valid  = 1'b1;
                    n_out_status = ST_DRAINED;
                    n_out_item   = cell_item[0];
                    n_count      = r_count - CNT_W'(1);
                    n_out_count  = r_count - CNT_W'(1);
                    n_out_last   = (r_count == CNT_W'(1));
                    if (r_count == CNT_W'(1)) begin
                        n_state     = S_IDLE;
                        n_cmd_valid = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd_valid <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd_valid <= n_cmd_valid;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_mode       <= n_mode;
        r_value      <= n_value;
        r_out_status <= n_out_status;
        r_out_item   <= n_out_item;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
    end

    assign i_in.ready        = !r_cmd_valid;
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.item_value  = r_out_item;
    assign o_out.count_after = COUNT_OUT_W'(r_out_count);
    assign o_out.last        = r_out_last;
endmodule
`default_nettype wire

### src/olpd_chk.sv
// Port-level checker for the ordered list block, bound to the top level.
`default_nettype none
module olpd_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [olpd_pkg::STATUS_W-1:0]     i_status,
    input logic [olpd_pkg::ITEM_W-1:0]       i_item_value,
    input logic [olpd_pkg::COUNT_OUT_W-1:0]  i_count_after,
    input logic                              i_last
);
    import olpd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_zero_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_APPENDED || i_status == ST_IGNORED ||
                        i_status == ST_FULL || i_status == ST_EMPTY)
        |-> i_item_value == '0)
        else $error("item value not zero for a status without item");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_DRAINED |-> i_last)
        else $error("command result without last");

    a_drain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_DRAINED |-> (i_last == (i_count_after == '0)))
        else $error("drain last flag disagrees with count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_FULL |-> i_count_after == COUNT_OUT_W'(DEPTH))
        else $error("full drop with list not full");
endmodule

bind ordered_list_positional_delete_core olpd_chk u_olpd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_status      (o_out.status),
    .i_item_value  (o_out.item_value),
    .i_count_after (o_out.count_after),
    .i_last        (o_out.last)
);
`default_nettype wire
